// ===== hw/rtl/run_length_byte_encoder_assert.svh =====
// Assertion macros for the run-length byte encoder.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef RUN_LENGTH_BYTE_ENCODER_ASSERT_SVH
`define RUN_LENGTH_BYTE_ENCODER_ASSERT_SVH

// Consequent checked in the cycle after the antecedent.
`define RLBE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("run-length encoder check failed");

// Consequent checked in the same cycle as the antecedent.
`define RLBE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("run-length encoder check failed");

`endif

// ===== hw/rtl/rlbe_pkg.sv =====
`default_nettype none

package rlbe_pkg;

    // Largest count of extra copies held in one run
    localparam logic [3:0] MAX_REPEAT = 4'd9;

    localparam logic [7:0] ESCAPE_MARK = 8'h24;
    localparam logic [7:0] DIGIT_ZERO  = 8'h30;

    localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

    // One encoded run: up to three bytes, left aligned
    typedef struct packed {
        logic [2:0][7:0] sym;
        logic [1:0]      len;
    } run_t;

    // Bytes caused by one input beat: a closed run and a flushed run
    typedef struct packed {
        logic [5:0][7:0] bytes;
        logic [2:0]      len;
        logic            flush;
    } burst_t;

    function automatic run_t encode_run(input logic [7:0] value, input logic [3:0] count);
        run_t r;
        r = '0;
        r.sym[0] = value;
        if (count > 4'd1)
        begin
            r.sym[1] = ESCAPE_MARK;
            r.sym[2] = DIGIT_ZERO + {4'b0000, count};
            r.len    = 2'd3;
        end
        else if (count == 4'd1)
        begin
            r.sym[1] = value;
            r.len    = 2'd2;
        end
        else
        begin
            r.len = 2'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rlbe_raw_if.sv =====
`default_nettype none

interface rlbe_raw_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rlbe_coded_if.sv =====
`default_nettype none

interface rlbe_coded_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        last_of_burst;
    logic [31:0] total_written;

    modport source (output valid, output out_byte, output last_of_burst,
                    output total_written, input ready);
    modport sink   (input valid, input out_byte, input last_of_burst,
                    input total_written, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rlbe_encoder.sv =====
`default_nettype none

module rlbe_encoder (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      in_byte,
    input  wire logic            end_of_stream,
    output rlbe_pkg::burst_t     burst
);
    import rlbe_pkg::*;

    logic       have_reg, have_next;
    logic [7:0] pend_reg, pend_next;
    logic [3:0] rep_reg,  rep_next;

    logic       extend;
    logic [1:0] len_a;
    logic [1:0] len_b;
    logic [7:0] new_pend;
    logic [3:0] new_rep;
    run_t       run_a;
    run_t       run_b;

    // Decide whether the beat extends the run or closes it
    always_comb
    begin
        extend   = have_reg && (in_byte == pend_reg) && (rep_reg < MAX_REPEAT);
        run_a    = encode_run(pend_reg, rep_reg);
        len_a    = (have_reg && !extend) ? run_a.len : 2'd0;
        new_pend = extend ? pend_reg : in_byte;
        new_rep  = extend ? rep_reg + 4'd1 : 4'd0;
        run_b    = encode_run(new_pend, new_rep);
        len_b    = end_of_stream ? run_b.len : 2'd0;
    end

    // Pack the closed run and the flushed run back to back
    always_comb
    begin
        burst = '0;
        burst.bytes[2:0] = run_a.sym;
        case (len_a)
            2'd0:    burst.bytes[2:0] = run_b.sym;
            2'd1:    burst.bytes[3:1] = run_b.sym;
            2'd2:    burst.bytes[4:2] = run_b.sym;
            default: burst.bytes[5:3] = run_b.sym;
        endcase
        burst.len   = {1'b0, len_a} + {1'b0, len_b};
        burst.flush = end_of_stream;
    end

    // Advance the run state on each accepted beat; clear it after a flush
    always_comb
    begin
        have_next = have_reg;
        pend_next = pend_reg;
        rep_next  = rep_reg;
        if (accept)
        begin
            if (end_of_stream)
            begin
                have_next = 1'b0;
                pend_next = 8'd0;
                rep_next  = 4'd0;
            end
            else
            begin
                have_next = 1'b1;
                pend_next = new_pend;
                rep_next  = new_rep;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            pend_reg <= 8'd0;
            rep_reg  <= 4'd0;
        end
        else
        begin
            have_reg <= have_next;
            pend_reg <= pend_next;
            rep_reg  <= rep_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rlbe_serializer.sv =====
`default_nettype none

module rlbe_serializer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire rlbe_pkg::burst_t burst,
    output logic                  load_ok,
    rlbe_coded_if.source          coded
);
    import rlbe_pkg::*;

    burst_t      burst_reg, burst_next;
    logic        busy_reg,  busy_next;
    logic [2:0]  idx_reg,   idx_next;
    logic [31:0] total_reg, total_next;

    logic        fire;
    logic        last;

    // Present the byte under the index
    always_comb
    begin
        last                = (idx_reg == burst_reg.len - 3'd1);
        fire                = busy_reg && coded.ready;
        load_ok             = !busy_reg || (fire && last);
        coded.valid         = busy_reg;
        coded.out_byte      = burst_reg.bytes[idx_reg];
        coded.last_of_burst = last;
        coded.total_written = total_reg;
    end

    // Step through the burst; take the next one as the last beat leaves
    always_comb
    begin
        burst_next = burst_reg;
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        total_next = total_reg;
        if (fire)
        begin
            if (last && burst_reg.flush)
                total_next = 32'd1;
            else if (total_reg != TOTAL_MAX)
                total_next = total_reg + 32'd1;
        end
        if (load && load_ok)
        begin
            burst_next = burst;
            busy_next  = 1'b1;
            idx_next   = 3'd0;
        end
        else if (fire && last)
        begin
            busy_next = 1'b0;
        end
        else if (fire)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            idx_reg   <= 3'd0;
            total_reg <= 32'd1;
        end
        else
        begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            total_reg <= total_next;
        end
    end

    // Hold the burst payload
    always_ff @(posedge clk)
    begin
        burst_reg <= burst_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/run_length_byte_encoder.sv =====
// Run-length byte encoder with a '$' escape marker.
// Channel raw takes one byte a beat with end_of_stream marking the final
// byte of a stream. Channel coded gives the encoded bytes one a beat, with
// last_of_burst on the final byte caused by one raw beat and total_written
// counting bytes of the current stream (saturating at all ones).
// A raw beat causes zero to four coded bytes. The first of them appears on
// coded in the cycle after the raw beat is taken; the rest follow one per
// cycle while coded is ready.
// Throughput: one raw beat per cycle while each beat causes at most one
// coded byte and coded is ready. Otherwise raw waits until the serialiser has
// the last byte of the current burst taken, so output runs at one byte per
// cycle while coded is ready, set by the single output register stage.
// A raw beat causing no byte is accepted whenever the serialiser can load.
// Reset clears the run state, empties the output stage and restarts the
// byte count. If coded stalls, the current byte holds and raw stays held
// off until the last byte of the held burst is taken.
`default_nettype none

module run_length_byte_encoder (
    input  wire logic    clk,
    input  wire logic    rst_n,
    rlbe_raw_if.sink     raw,
    rlbe_coded_if.source coded
);
    import rlbe_pkg::*;

    burst_t burst;
    logic   load_ok;
    logic   accept;

    // Take a raw beat whenever the serialiser can load a burst
    assign raw.ready = load_ok;
    assign accept    = raw.valid && load_ok;

    rlbe_encoder u_encoder (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (raw.in_byte),
        .end_of_stream (raw.end_of_stream),
        .burst         (burst)
    );

    rlbe_serializer u_serializer (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept && (burst.len != 3'd0)),
        .burst   (burst),
        .load_ok (load_ok),
        .coded   (coded)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/rlbe_checker.sv =====
`default_nettype none

`include "run_length_byte_encoder_assert.svh"

module rlbe_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        raw_valid,
    input wire logic        raw_ready,
    input wire logic        raw_eos,
    input wire logic        coded_valid,
    input wire logic        coded_ready,
    input wire logic [7:0]  coded_byte,
    input wire logic        coded_last,
    input wire logic [31:0] coded_total
);

    logic coded_stall;
    logic coded_more;
    logic coded_step;
    logic raw_flush;

    // Name the handshake conditions used below
    assign coded_stall = coded_valid && !coded_ready;
    assign coded_more  = coded_valid && coded_ready && !coded_last;
    assign coded_step  = coded_more && (coded_total != 32'hFFFF_FFFF);
    assign raw_flush   = raw_valid && raw_ready && raw_eos;

    // A stalled byte holds
    `RLBE_ASSERT_NEXT(a_stall_hold, coded_stall, coded_valid && $stable({coded_byte, coded_total}))

    // A burst runs without gaps
    `RLBE_ASSERT_NEXT(a_burst_dense, coded_more, coded_valid)

    // Within a burst the count steps by one until saturation
    `RLBE_ASSERT_NEXT(a_count_step, coded_step, coded_total == $past(coded_total) + 32'd1)

    // A flush always yields output next cycle
    `RLBE_ASSERT_NEXT(a_flush_out, raw_flush, coded_valid)

    // An empty output stage never holds off the input
    `RLBE_ASSERT_SAME(a_idle_ready, !coded_valid, raw_ready)

endmodule

bind run_length_byte_encoder rlbe_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .raw_valid   (raw.valid),
    .raw_ready   (raw.ready),
    .raw_eos     (raw.end_of_stream),
    .coded_valid (coded.valid),
    .coded_ready (coded.ready),
    .coded_byte  (coded.out_byte),
    .coded_last  (coded.last_of_burst),
    .coded_total (coded.total_written)
);

`default_nettype wire
